FILE: rtl/core/cdq_pkg.sv
// shared types and constants of the circular deque
`default_nettype none

package cdq_pkg;

  // widths of the request and result fields
  localparam int unsigned ModeW   = 2;
  localparam int unsigned IoDataW = 32;
  localparam int unsigned StatusW = 2;
  localparam int unsigned CountW  = 5;

  typedef enum logic [ModeW-1:0] {
    MODE_PUSH_BACK  = 2'd0,
    MODE_PUSH_FRONT = 2'd1,
    MODE_POP_FRONT  = 2'd2,
    MODE_POP_BACK   = 2'd3
  } mode_t;

  typedef enum logic [StatusW-1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    ST_IDLE,
    ST_FIN
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic exec;
    logic load_out;
  } cmd_t;

endpackage

`default_nettype wire

FILE: rtl/core/cdq_datapath.sv
// ring storage, pointers, fill count and result register of the deque
`default_nettype none

module cdq_datapath #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                             clk,
  input  wire                             rst_n,
  input  cdq_pkg::cmd_t                   cmd,
  input  wire  [cdq_pkg::ModeW-1:0]       in_mode,
  input  wire  signed [cdq_pkg::IoDataW-1:0] in_data_in,
  output logic signed [cdq_pkg::IoDataW-1:0] out_data_out,
  output logic [cdq_pkg::StatusW-1:0]     out_status,
  output logic [cdq_pkg::CountW-1:0]      out_fill_count
);
  import cdq_pkg::*;

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [DATA_WIDTH-1:0] mem [DEPTH];

  logic [AW-1:0] front_r, front_nxt;
  logic [AW-1:0] back_r, back_nxt;
  logic [CW-1:0] count_r, count_nxt;

  logic [DATA_WIDTH-1:0] rd_data_r;
  logic                  pop_ok_r;
  status_t               res_status_r;
  logic [CW-1:0]         res_count_r;

  logic [IoDataW-1:0] out_data_r;
  status_t            out_status_r;
  logic [CountW-1:0]  out_count_r;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         wr_addr, rd_addr;
  logic [DATA_WIDTH-1:0] wr_word;
  logic [IoDataW-1:0]    pop_word;
  logic [CountW-1:0]     count_io;
  status_t               st;
  logic                  pop_ok;
  logic                  full, empty;
  mode_t                 mode;

  function automatic logic [AW-1:0] idx_next(input logic [AW-1:0] i);
    idx_next = (i == AW'(DEPTH - 1)) ? '0 : i + AW'(1);
  endfunction

  function automatic logic [AW-1:0] idx_prev(input logic [AW-1:0] i);
    idx_prev = (i == '0) ? AW'(DEPTH - 1) : i - AW'(1);
  endfunction

  // word and count width adaption
  if (DATA_WIDTH <= IoDataW) begin : g_wr_narrow
    assign wr_word = in_data_in[DATA_WIDTH-1:0];
  end else begin : g_wr_wide
    assign wr_word = {{(DATA_WIDTH - IoDataW){1'b0}}, in_data_in};
  end

  if (DATA_WIDTH >= IoDataW) begin : g_rd_wide
    assign pop_word = rd_data_r[IoDataW-1:0];
  end else begin : g_rd_narrow
    assign pop_word = {{(IoDataW - DATA_WIDTH){1'b0}}, rd_data_r};
  end

  if (CW >= CountW) begin : g_cnt_wide
    assign count_io = res_count_r[CountW-1:0];
  end else begin : g_cnt_narrow
    assign count_io = {{(CountW - CW){1'b0}}, res_count_r};
  end

  assign mode  = mode_t'(in_mode);
  assign full  = (count_r == CW'(DEPTH));
  assign empty = (count_r == '0);

  always_comb begin
    front_nxt = front_r;
    back_nxt  = back_r;
    count_nxt = count_r;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    wr_addr   = back_r;
    rd_addr   = front_r;
    st        = STAT_OK;
    pop_ok    = 1'b0;
    if (cmd.exec) begin
      case (mode)
        MODE_PUSH_BACK: begin
          if (full) begin
            st = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            wr_addr   = back_r;
            back_nxt  = idx_next(back_r);
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_PUSH_FRONT: begin
          if (full) begin
            st = STAT_FULL;
          end else begin
            mem_we    = 1'b1;
            wr_addr   = idx_prev(front_r);
            front_nxt = idx_prev(front_r);
            count_nxt = count_r + CW'(1);
          end
        end
        MODE_POP_FRONT: begin
          if (empty) begin
            st = STAT_EMPTY;
          end else begin
            mem_re    = 1'b1;
            pop_ok    = 1'b1;
            rd_addr   = front_r;
            front_nxt = idx_next(front_r);
            count_nxt = count_r - CW'(1);
          end
        end
        MODE_POP_BACK: begin
          if (empty) begin
            st = STAT_EMPTY;
          end else begin
            mem_re    = 1'b1;
            pop_ok    = 1'b1;
            rd_addr   = idx_prev(back_r);
            back_nxt  = idx_prev(back_r);
            count_nxt = count_r - CW'(1);
          end
        end
        default: begin
          st = STAT_OK;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_word;
    end
    if (mem_re) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r <= '0;
      back_r  <= '0;
      count_r <= '0;
    end else begin
      front_r <= front_nxt;
      back_r  <= back_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      pop_ok_r     <= pop_ok;
      res_status_r <= st;
      res_count_r  <= count_nxt;
    end
    if (cmd.load_out) begin
      out_data_r   <= pop_ok_r ? pop_word : '0;
      out_status_r <= res_status_r;
      out_count_r  <= count_io;
    end
  end

  assign out_data_out   = out_data_r;
  assign out_status     = out_status_r;
  assign out_fill_count = out_count_r;

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("fill count above depth");

  // front plus count lands on back, either directly or after one wrap
  a_ring_consistent: assert property (@(posedge clk) disable iff (!rst_n)
    ((CW+1)'(front_r) + (CW+1)'(count_r) == (CW+1)'(back_r)) ||
    ((CW+1)'(front_r) + (CW+1)'(count_r) == (CW+1)'(back_r) + (CW+1)'(DEPTH)))
    else $error("front, back and count disagree");

  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec && ((full && (mode == MODE_PUSH_BACK || mode == MODE_PUSH_FRONT)) ||
                 (empty && (mode == MODE_POP_FRONT || mode == MODE_POP_BACK)))
    |=> $stable(front_r) && $stable(back_r) && $stable(count_r))
    else $error("rejected request changed the ring");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/cdq_ctrl.sv
// request sequencing and result handshake of the deque
`default_nettype none

module cdq_ctrl (
  input  wire           clk,
  input  wire           rst_n,
  input  wire           in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  wire           out_stall,
  output cdq_pkg::cmd_t cmd
);
  import cdq_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_stall     = 1'b1;
    cmd.exec     = 1'b0;
    cmd.load_out = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        cmd.exec = in_valid;
      end
      ST_FIN: begin
        cmd.load_out = out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

`ifndef SYNTHESIS
  a_exec_to_fin: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> state_r == ST_FIN)
    else $error("accepted word did not reach finish state");

  a_fin_publishes: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && !out_valid_r) |=> out_valid_r && state_r == ST_IDLE)
    else $error("result not published with free output");

  a_fin_waits: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FIN && out_valid_r && out_stall) |=> state_r == ST_FIN)
    else $error("result overwritten while output stalled");
`endif

endmodule

`default_nettype wire

FILE: rtl/core/circular_deque.sv
// top level of the circular deque
`default_nettype none

// circular deque: a double-ended queue of DEPTH words of DATA_WIDTH bits held
// in a ring buffer. each request word carries a mode (push back, push front,
// pop front, pop back) and a data word, and yields exactly one result word:
// the popped data (zero for pushes and errors), a status (ok, full on push,
// empty on pop) and the fill count after the request. a rejected request
// leaves the deque unchanged. in the cycle a request is accepted it updates
// the pointers and writes or reads the ring memory; in the finish state,
// once the output register is free, the registered memory read moves into
// the output register. a new request is not taken before its predecessor
// has reached the output register. a finished result may wait in the
// output register while the next request is taken. ring slots are not
// cleared at reset: a pop only ever reads a slot that an earlier push wrote.
// pushed words are truncated or zero-extended to DATA_WIDTH bits, and popped
// words come back zero-extended or truncated to 32 bits.

module circular_deque #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  wire                                clk,
  input  wire                                rst_n,
  // request channel
  input  wire                                in_valid,
  output logic                               in_stall,
  input  wire  [cdq_pkg::ModeW-1:0]          in_mode,
  input  wire  signed [cdq_pkg::IoDataW-1:0] in_data_in,
  // result channel
  output logic                               out_valid,
  input  wire                                out_stall,
  output logic signed [cdq_pkg::IoDataW-1:0] out_data_out,
  output logic [cdq_pkg::StatusW-1:0]        out_status,
  output logic [cdq_pkg::CountW-1:0]         out_fill_count
);
  import cdq_pkg::*;

  // exec: perform the request on the ring; load_out: publish the result
  cmd_t cmd;

  // sequencing and output handshake
  cdq_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd)
  );

  // ring memory, pointers, fill count and result payload
  cdq_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_datapath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_mode        (in_mode),
    .in_data_in     (in_data_in),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

endmodule

`default_nettype wire

FILE: dv/tb_circular_deque.sv
// self-checking testbench for the circular deque: directed table, then biased random traffic
module tb_circular_deque;
  timeunit 1ns;
  timeprecision 1ps;

  import cdq_pkg::*;

  localparam int unsigned RingDepth = 16;
  localparam int unsigned WordW     = 32;
  localparam int unsigned RandWords = 500;
  localparam int unsigned ShowLimit = 10;

  // one result word as the deque reports it
  typedef struct packed {
    logic [IoDataW-1:0] word;
    status_t            status;
    logic [CountW-1:0]  fill;
  } deque_result_t;

  // one row of the directed table; typed rows carry their own expected result
  typedef struct {
    mode_t              mode;
    logic [IoDataW-1:0] data;
    bit                 typed;
    deque_result_t      want;
  } script_row_t;

  logic                      clk       = 1'b0;
  logic                      rst_n     = 1'b0;
  logic                      in_valid  = 1'b0;
  logic                      in_stall;
  logic [ModeW-1:0]          in_mode   = '0;
  logic signed [IoDataW-1:0] in_data_in = '0;
  logic                      out_valid;
  logic                      out_stall = 1'b0;
  logic signed [IoDataW-1:0] out_data_out;
  logic [StatusW-1:0]        out_status;
  logic [CountW-1:0]         out_fill_count;

  // typed expectation travels with the request word, same timing as its pins
  logic          row_typed = 1'b0;
  deque_result_t row_want  = '0;

  // when set, neither side inserts bubbles
  bit steady = 1'b0;

  // shadow deque state used for prediction
  logic [WordW-1:0]  shadow_ring [RingDepth];
  logic [3:0]        shadow_head = '0;
  logic [3:0]        shadow_tail = '0;
  logic [CountW-1:0] shadow_count = '0;

  deque_result_t pending_results [$];

  int unsigned fail_count = 0;
  int unsigned n_push_ok  = 0;
  int unsigned n_pop_ok   = 0;
  int unsigned n_full     = 0;
  int unsigned n_empty    = 0;
  int unsigned n_checked  = 0;

  circular_deque #(
    .DEPTH      (RingDepth),
    .DATA_WIDTH (WordW)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_mode        (in_mode),
    .in_data_in     (in_data_in),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_data_out   (out_data_out),
    .out_status     (out_status),
    .out_fill_count (out_fill_count)
  );

  always #5 clk = ~clk;

  // apply one request to the shadow deque and return what the block should report
  function automatic deque_result_t deque_apply(mode_t mode, logic [WordW-1:0] data);
    deque_result_t res;
    res = '{word: '0, status: STAT_OK, fill: '0};
    case (mode)
      MODE_PUSH_BACK, MODE_PUSH_FRONT: begin
        if (shadow_count >= RingDepth) begin
          res.status = STAT_FULL;
        end else if (mode == MODE_PUSH_BACK) begin
          shadow_ring[shadow_tail] = data;
          shadow_tail = shadow_tail + 4'd1;
          shadow_count = shadow_count + 1'b1;
        end else begin
          // front moves down first, wrapping below slot zero
          shadow_head = shadow_head - 4'd1;
          shadow_ring[shadow_head] = data;
          shadow_count = shadow_count + 1'b1;
        end
      end
      default: begin
        if (shadow_count == 0) begin
          res.status = STAT_EMPTY;
        end else if (mode == MODE_POP_FRONT) begin
          res.word = shadow_ring[shadow_head];
          shadow_head = shadow_head + 4'd1;
          shadow_count = shadow_count - 1'b1;
        end else begin
          // back index points one past the last word
          shadow_tail = shadow_tail - 4'd1;
          res.word = shadow_ring[shadow_tail];
          shadow_count = shadow_count - 1'b1;
        end
      end
    endcase
    res.fill = shadow_count;
    return res;
  endfunction

  task automatic note_failure(string msg);
    if (fail_count < ShowLimit) $display("mismatch: %s", msg);
    fail_count++;
  endtask

  // monitor: values read here are the ones present at the clock edge
  always @(posedge clk) begin
    deque_result_t want;
    deque_result_t got;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        want = deque_apply(mode_t'(in_mode), in_data_in);
        case (want.status)
          STAT_FULL:  n_full++;
          STAT_EMPTY: n_empty++;
          default: begin
            if (in_mode[1]) n_pop_ok++;
            else n_push_ok++;
          end
        endcase
        if (row_typed) want = row_want;
        pending_results.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = '{word: out_data_out, status: status_t'(out_status), fill: out_fill_count};
        if (pending_results.size() == 0) begin
          note_failure($sformatf("unexpected word data=%h status=%0d fill=%0d",
                                 got.word, got.status, got.fill));
        end else begin
          want = pending_results.pop_front();
          n_checked++;
          if (got.word !== want.word || got.status !== want.status ||
              got.fill !== want.fill) begin
            note_failure($sformatf(
              "exp data=%h status=%0d fill=%0d, got data=%h status=%0d fill=%0d",
              want.word, want.status, want.fill, got.word, got.status, got.fill));
          end
        end
      end
    end
  end

  // result side backpressure, off during the steady stretch
  always @(posedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < 28);
  end

  // drive one request word and hold it until the deque takes it
  task automatic send_request(mode_t mode, logic [WordW-1:0] data, bit typed,
                              deque_result_t want);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    in_mode    <= mode;
    in_data_in <= data;
    row_typed  <= typed;
    row_want   <= want;
    do @(posedge clk); while (in_stall);
  endtask

  // stimulus
  initial begin
    script_row_t script [25];
    int unsigned push_pct;
    int unsigned pct_choices [5];
    int unsigned waited;
    logic [WordW-1:0] word;
    mode_t mode;

    pct_choices = '{5, 20, 50, 80, 95};

    // after reset: empty rejects on both ends, extremes through both ends,
    // front push and back pop that wrap below slot zero, then fill to full
    script[0]  = '{MODE_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0, STAT_EMPTY, 5'd0}};
    script[1]  = '{MODE_POP_BACK,   32'hffff_ffff, 1'b1, '{32'h0, STAT_EMPTY, 5'd0}};
    script[2]  = '{MODE_PUSH_BACK,  32'h7fff_ffff, 1'b1, '{32'h0, STAT_OK, 5'd1}};
    script[3]  = '{MODE_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0, STAT_OK, 5'd2}};
    script[4]  = '{MODE_POP_BACK,   32'h0000_0000, 1'b1, '{32'h7fff_ffff, STAT_OK, 5'd1}};
    script[5]  = '{MODE_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h8000_0000, STAT_OK, 5'd0}};
    script[6]  = '{MODE_PUSH_FRONT, 32'hffff_ffff, 1'b1, '{32'h0, STAT_OK, 5'd1}};
    script[7]  = '{MODE_POP_BACK,   32'h0000_0000, 1'b1, '{32'hffff_ffff, STAT_OK, 5'd0}};
    script[8]  = '{MODE_PUSH_BACK,  32'h0000_0000, 1'b0, '0};
    script[9]  = '{MODE_PUSH_FRONT, 32'hffff_ffff, 1'b0, '0};
    script[10] = '{MODE_PUSH_BACK,  32'h1234_5678, 1'b0, '0};
    script[11] = '{MODE_PUSH_FRONT, 32'hdead_beef, 1'b0, '0};
    script[12] = '{MODE_PUSH_BACK,  32'h8000_0000, 1'b0, '0};
    script[13] = '{MODE_PUSH_FRONT, 32'h7fff_ffff, 1'b0, '0};
    script[14] = '{MODE_PUSH_BACK,  32'h5555_aaaa, 1'b0, '0};
    script[15] = '{MODE_PUSH_FRONT, 32'haaaa_5555, 1'b0, '0};
    script[16] = '{MODE_PUSH_BACK,  32'h0000_0001, 1'b0, '0};
    script[17] = '{MODE_PUSH_FRONT, 32'hfedc_ba98, 1'b0, '0};
    script[18] = '{MODE_PUSH_BACK,  32'h0f0f_0f0f, 1'b0, '0};
    script[19] = '{MODE_PUSH_FRONT, 32'hf0f0_f0f0, 1'b0, '0};
    script[20] = '{MODE_PUSH_BACK,  32'h3333_cccc, 1'b0, '0};
    script[21] = '{MODE_PUSH_FRONT, 32'hcccc_3333, 1'b0, '0};
    script[22] = '{MODE_PUSH_BACK,  32'h0001_0000, 1'b0, '0};
    script[23] = '{MODE_PUSH_FRONT, 32'h8765_4321, 1'b0, '0};
    // deque now holds sixteen words, so one more push bounces
    script[24] = '{MODE_PUSH_BACK,  32'h5a5a_5a5a, 1'b1, '{32'h0, STAT_FULL, 5'd16}};

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (script[i]) send_request(script[i].mode, script[i].data, script[i].typed,
                                     script[i].want);

    // random part starts from a full deque; push bias changes every 32 words so
    // the fill level sweeps between empty and full and the pointers wrap often
    push_pct = 20;
    for (int unsigned n = 0; n < RandWords; n++) begin
      if (n % 32 == 0) push_pct = pct_choices[$urandom_range(0, 4)];
      steady = (n >= 150 && n < 270);
      // hold off once until the pipeline has fully drained
      if (n == 350) begin
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
      end
      if ($urandom_range(0, 99) < push_pct) mode = mode_t'($urandom_range(0, 1));
      else mode = mode_t'(2 + $urandom_range(0, 1));
      case ($urandom_range(0, 15))
        0:       word = 32'h0000_0000;
        1:       word = 32'hffff_ffff;
        2:       word = 32'h8000_0000;
        3:       word = 32'h7fff_ffff;
        default: word = $urandom();
      endcase
      send_request(mode, word, 1'b0, '0);
    end
    steady = 1'b0;
    in_valid <= 1'b0;

    // drain, bounded
    waited = 0;
    while (pending_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    repeat (10) @(posedge clk);

    foreach (pending_results[i]) begin
      note_failure($sformatf("no word for exp data=%h status=%0d fill=%0d",
                             pending_results[i].word, pending_results[i].status,
                             pending_results[i].fill));
    end

    $display("checked %0d results: %0d pushes and %0d pops taken, %0d full and %0d empty rejects",
             n_checked, n_push_ok, n_pop_ok, n_full, n_empty);
    $display("mismatches: %0d", fail_count);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #1ms;
    $display("TEST FAILED");
    $finish;
  end

endmodule
